[hw/rtl/fwh_pkg.sv]
// ----------------------------------------------------------------------------
// fwh_pkg: shared definitions for the fixed-width bin histogram
// Field widths, register indexes, reset values, state and class codes.
// ----------------------------------------------------------------------------
package fwh_pkg;

   // Field widths
   localparam int SAMPLE_W    = 32;
   localparam int WIDTH_W     = 31;
   localparam int COUNT_W     = 7;
   localparam int CNT_W       = 32;
   localparam int INDEX_W     = 6;
   localparam int CLASS_W     = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // Serial divider: one quotient bit per step
   localparam int DIV_STEPS = SAMPLE_W;

   // Built maximum number of buckets
   localparam int MAX_BINS_DEFAULT = 64;

   // Register reset values
   localparam logic [SAMPLE_W-1:0] RANGE_START_RST  = '0;
   localparam logic [WIDTH_W-1:0]  BUCKET_WIDTH_RST = WIDTH_W'(1);
   localparam logic [COUNT_W-1:0]  BUCKET_COUNT_RST = COUNT_W'(36);

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RANGE_START  = 2'd0,
      CSR_BUCKET_WIDTH = 2'd1,
      CSR_BUCKET_COUNT = 2'd2
   } csr_reg_type;

   // Result class codes
   typedef enum logic [CLASS_W-1:0] {
      CLASS_IN    = 2'd0,
      CLASS_BELOW = 2'd1,
      CLASS_ABOVE = 2'd2
   } sample_class_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_CLASSIFY,
      ST_UPDATE
   } state_type;

   // Saturating counter increment
   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] cnt);
      return (cnt == '1) ? cnt : cnt + CNT_W'(1);
   endfunction

endpackage

[hw/rtl/fwh_ram.sv]
// ----------------------------------------------------------------------------
// fwh_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fwh_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/fwh_divider.sv]
// ----------------------------------------------------------------------------
// fwh_divider: restoring serial divider
// Unsigned 32-bit dividend by 31-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fwh_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fwh_pkg::SAMPLE_W-1:0]  dividend,
   input  logic [fwh_pkg::WIDTH_W-1:0]   divisor,
   output logic                          done,
   output logic [fwh_pkg::SAMPLE_W-1:0]  quotient
);

   localparam int DVD_W  = fwh_pkg::SAMPLE_W;
   localparam int DVS_W  = fwh_pkg::WIDTH_W;
   localparam int STEP_W = $clog2(fwh_pkg::DIV_STEPS);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;

   logic [DVS_W:0]    partial;
   logic [DVS_W:0]    trial;
   logic              fits;
   logic              last_step;

   // One restoring step: shift in the next dividend bit, try a subtract
   always_comb begin
      partial   = {rem_ff, quo_ff[DVD_W-1]};
      trial     = partial - {1'b0, dvs_ff};
      fits      = partial >= {1'b0, dvs_ff};
      last_step = step_ff == STEP_W'(fwh_pkg::DIV_STEPS - 1);
   end

   // Next-value logic
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? trial[DVS_W-1:0] : partial[DVS_W-1:0];
         quo_in  = {quo_ff[DVD_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[hw/rtl/fixed_width_histogram_top.sv]
// ----------------------------------------------------------------------------
// fixed_width_histogram_top: fixed-width bin histogram
// Bins signed samples by floor((sample - range_start) / bucket_width) and
// keeps saturating per-bucket and out-of-range counters.
// ----------------------------------------------------------------------------
// Each sample goes from acceptance to a valid result in order: the serial
// divider forms the quotient (one quotient bit per cycle), the divider raises
// its registered done flag, the sequencer classifies the sample and reads the
// bucket counter from the RAM, and then it writes the incremented count back
// and loads the result register. A new sample is taken only in the idle
// state, once the previous one has been written back, so samples never
// overlap in the divider or the counter RAM.
// The input is accepted only while the sequencer is idle; a finished result
// waits in its output register while the next sample is taken, and a
// transaction stalls in its last cycle only if the previous result is still
// unclaimed. After reset the bucket RAM is swept to zero, one entry per
// cycle, all MAX_BINS entries, before the first sample is taken; configuration
// writes are taken at any time. Samples below range_start are always below
// range (floored division); a bucket_width of zero acts as one, and a
// bucket_count above MAX_BINS acts as MAX_BINS.
module fixed_width_histogram_top #(
   parameter int MAX_BINS = fwh_pkg::MAX_BINS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // Sample input
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [fwh_pkg::SAMPLE_W-1:0] req_sample_value,
   // Result output
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [fwh_pkg::CLASS_W-1:0]      rsp_sample_class,
   output logic [fwh_pkg::INDEX_W-1:0]      rsp_bin_index,
   output logic [fwh_pkg::CNT_W-1:0]        rsp_bin_total,
   output logic [fwh_pkg::CNT_W-1:0]        rsp_below_total,
   output logic [fwh_pkg::CNT_W-1:0]        rsp_above_total,
   // Configuration write port
   input  logic                             csr_we,
   input  logic [fwh_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fwh_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int ADDR_W = $clog2(MAX_BINS);
   localparam int SMP_W  = fwh_pkg::SAMPLE_W;
   localparam int CNT_W  = fwh_pkg::CNT_W;
   localparam int IDX_W  = fwh_pkg::INDEX_W;

   // Configuration registers
   logic [SMP_W-1:0]                  range_start_ff, range_start_in;
   logic [fwh_pkg::WIDTH_W-1:0]       bucket_width_ff, bucket_width_in;
   logic [fwh_pkg::COUNT_W-1:0]       bucket_count_ff, bucket_count_in;

   // Sequencer and datapath state
   fwh_pkg::state_type                state_ff, state_in;
   logic [ADDR_W-1:0]                 clr_addr_ff, clr_addr_in;
   logic                              below_ff, below_in;
   fwh_pkg::sample_class_type         class_ff, class_in;
   logic [CNT_W-1:0]                  under_ff, under_in;
   logic [CNT_W-1:0]                  over_ff, over_in;

   // Result register
   logic                              rsp_valid_ff, rsp_valid_in;
   fwh_pkg::sample_class_type         rsp_class_ff, rsp_class_in;
   logic [IDX_W-1:0]                  rsp_index_ff, rsp_index_in;
   logic [CNT_W-1:0]                  rsp_total_ff, rsp_total_in;
   logic [CNT_W-1:0]                  rsp_below_ff, rsp_below_in;
   logic [CNT_W-1:0]                  rsp_above_ff, rsp_above_in;

   // Internal nets
   logic                              accept;
   logic                              clr_last;
   logic                              out_free;
   logic                              commit;
   logic [SMP_W:0]                    offset;
   logic [fwh_pkg::WIDTH_W-1:0]       divisor;
   logic                              div_done;
   logic [SMP_W-1:0]                  quotient;
   logic [SMP_W-1:0]                  limit;
   logic [CNT_W-1:0]                  bin_next;
   logic                              ram_we;
   logic [ADDR_W-1:0]                 ram_waddr;
   logic [CNT_W-1:0]                  ram_wdata;
   logic                              ram_re;
   logic [CNT_W-1:0]                  ram_rdata;

   // Configuration writes
   always_comb begin
      range_start_in  = range_start_ff;
      bucket_width_in = bucket_width_ff;
      bucket_count_in = bucket_count_ff;
      if (csr_we) begin
         unique case (fwh_pkg::csr_reg_type'(csr_index))
            fwh_pkg::CSR_RANGE_START:  range_start_in  = csr_wdata;
            fwh_pkg::CSR_BUCKET_WIDTH: bucket_width_in = csr_wdata[fwh_pkg::WIDTH_W-1:0];
            fwh_pkg::CSR_BUCKET_COUNT: bucket_count_in = csr_wdata[fwh_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_start_ff  <= fwh_pkg::RANGE_START_RST;
         bucket_width_ff <= fwh_pkg::BUCKET_WIDTH_RST;
         bucket_count_ff <= fwh_pkg::BUCKET_COUNT_RST;
      end else begin
         range_start_ff  <= range_start_in;
         bucket_width_ff <= bucket_width_in;
         bucket_count_ff <= bucket_count_in;
      end
   end

   // Handshake and shared terms
   always_comb begin
      accept   = req_valid && req_ready;
      clr_last = clr_addr_ff == ADDR_W'(MAX_BINS - 1);
      out_free = !rsp_valid_ff || rsp_ready;
      commit   = (state_ff == fwh_pkg::ST_UPDATE) && out_free;
      // 33-bit signed offset of the sample from the range start
      offset   = {req_sample_value[SMP_W-1], req_sample_value}
               - {range_start_ff[SMP_W-1], range_start_ff};
      divisor  = (bucket_width_ff == '0) ? fwh_pkg::WIDTH_W'(1) : bucket_width_ff;
      // Effective bucket limit, clamped to the built maximum
      limit    = (SMP_W'(bucket_count_ff) > SMP_W'(MAX_BINS))
               ? SMP_W'(MAX_BINS) : SMP_W'(bucket_count_ff);
      bin_next = fwh_pkg::sat_inc(ram_rdata);
   end

   // Serial divider
   fwh_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend (offset[SMP_W-1:0]),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   // Bucket counter RAM
   fwh_ram #(
      .DATA_W (CNT_W),
      .DEPTH  (MAX_BINS),
      .ADDR_W (ADDR_W)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (quotient[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   // Next-state logic
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fwh_pkg::ST_CLEAR:    if (clr_last) state_in = fwh_pkg::ST_IDLE;
         fwh_pkg::ST_IDLE:     if (req_valid) state_in = fwh_pkg::ST_DIVIDE;
         fwh_pkg::ST_DIVIDE:   if (div_done) state_in = fwh_pkg::ST_CLASSIFY;
         fwh_pkg::ST_CLASSIFY: state_in = fwh_pkg::ST_UPDATE;
         fwh_pkg::ST_UPDATE:   if (out_free) state_in = fwh_pkg::ST_IDLE;
         default:              state_in = fwh_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = quotient[ADDR_W-1:0];
      ram_wdata = bin_next;
      ram_re    = 1'b0;
      unique case (state_ff)
         fwh_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_ff;
            ram_wdata = '0;
         end
         fwh_pkg::ST_IDLE:     req_ready = 1'b1;
         fwh_pkg::ST_DIVIDE:   ;
         fwh_pkg::ST_CLASSIFY: ram_re = 1'b1;
         fwh_pkg::ST_UPDATE:   ram_we = out_free && (class_ff == fwh_pkg::CLASS_IN);
         default:              ;
      endcase
   end

   // Datapath next values
   always_comb begin
      clr_addr_in  = (state_ff == fwh_pkg::ST_CLEAR) ? clr_addr_ff + ADDR_W'(1) : clr_addr_ff;
      below_in     = accept ? offset[SMP_W] : below_ff;
      class_in     = class_ff;
      if (state_ff == fwh_pkg::ST_CLASSIFY) begin
         if (below_ff) begin
            class_in = fwh_pkg::CLASS_BELOW;
         end else if (quotient >= limit) begin
            class_in = fwh_pkg::CLASS_ABOVE;
         end else begin
            class_in = fwh_pkg::CLASS_IN;
         end
      end
      under_in = under_ff;
      over_in  = over_ff;
      if (commit && (class_ff == fwh_pkg::CLASS_BELOW)) begin
         under_in = fwh_pkg::sat_inc(under_ff);
      end
      if (commit && (class_ff == fwh_pkg::CLASS_ABOVE)) begin
         over_in = fwh_pkg::sat_inc(over_ff);
      end
   end

   // Result register next values
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_class_in = rsp_class_ff;
      rsp_index_in = rsp_index_ff;
      rsp_total_in = rsp_total_ff;
      rsp_below_in = rsp_below_ff;
      rsp_above_in = rsp_above_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
         rsp_class_in = class_ff;
         rsp_index_in = (class_ff == fwh_pkg::CLASS_IN) ? quotient[IDX_W-1:0] : '0;
         rsp_total_in = (class_ff == fwh_pkg::CLASS_IN) ? bin_next : '0;
         rsp_below_in = under_in;
         rsp_above_in = over_in;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fwh_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         under_ff     <= '0;
         over_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         under_ff     <= under_in;
         over_ff      <= over_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      below_ff     <= below_in;
      class_ff     <= class_in;
      rsp_class_ff <= rsp_class_in;
      rsp_index_ff <= rsp_index_in;
      rsp_total_ff <= rsp_total_in;
      rsp_below_ff <= rsp_below_in;
      rsp_above_ff <= rsp_above_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_class = rsp_class_ff;
   assign rsp_bin_index    = rsp_index_ff;
   assign rsp_bin_total    = rsp_total_ff;
   assign rsp_below_total  = rsp_below_ff;
   assign rsp_above_total  = rsp_above_ff;

   // Assertions

   // A pending result always carries the current out-of-range totals
   a_totals_track: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_below_total == under_ff) && (rsp_above_total == over_ff))
      else $error("result totals differ from the out-of-range counters");

   // An out-of-range result reports no bucket
   a_out_of_range_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_sample_class != fwh_pkg::CLASS_IN)
      |-> (rsp_bin_total == '0) && (rsp_bin_index == '0))
      else $error("out-of-range result reports a bucket");

   // An in-range commit always shows a nonzero bucket count
   a_in_range_nonzero: assert property (@(posedge clock) disable iff (reset)
      commit && (class_ff == fwh_pkg::CLASS_IN) |=> rsp_valid && (rsp_bin_total != '0))
      else $error("in-range result with zero bucket count");

endmodule
